// ===== sv/scrolling_two_digit_seven_segment_assert.svh =====
// Assertion macros shared by the scrolling display RTL.
`ifndef SCROLLING_TWO_DIGIT_SEVEN_SEGMENT_ASSERT_SVH
`define SCROLLING_TWO_DIGIT_SEVEN_SEGMENT_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define STDSS_ASSERT(label, ck, rs, cond, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);
// Checks that a condition holds in the cycle after a trigger.
`define STDSS_ASSERT_NEXT(label, ck, rs, trig, cond, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (trig) |=> (cond)) \
    else $error(msg);
`else
`define STDSS_ASSERT(label, ck, rs, cond, msg)
`define STDSS_ASSERT_NEXT(label, ck, rs, trig, cond, msg)
`endif

`endif

// ===== sv/stdss_pkg.sv =====
// Types, constants and lookup functions for the scrolling two-digit display.
package stdss_pkg;

  // Text store geometry.
  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int IDX_W     = 7;

  // Font table geometry and the decimal point code.
  localparam int FONT_SIZE = 65;
  localparam logic [IDX_W-1:0] DOT_INDEX = 7'd14;
  localparam logic [7:0]       DOT_BIT   = 8'h80;

  // Transaction kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_END    = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segments;
    logic       digit_select;
  } out_item_t;

  // Three consecutive font indices starting at the scroll position.
  typedef struct packed {
    logic [IDX_W-1:0] idx0;
    logic [IDX_W-1:0] idx1;
    logic [IDX_W-1:0] idx2;
  } window_t;

  // Patterns produced by one fetch, and whether a dot was folded in.
  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic       skip_dot;
  } glyph_t;

  localparam logic [7:0] FONT_ROM [FONT_SIZE] = '{
    8'h00, 8'h82, 8'h22, 8'h36, 8'h65, 8'h24, 8'h52, 8'h02,
    8'h39, 8'h0F, 8'h63, 8'h46, 8'h02, 8'h40, 8'h80, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h48, 8'h18, 8'h63, 8'h48, 8'h43, 8'h53,
    8'h5F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h06, 8'h1E, 8'hF2, 8'h38, 8'h55, 8'h54, 8'h3F,
    8'h73, 8'h67, 8'h31, 8'h6D, 8'h78, 8'h3E, 8'h1C, 8'h6A,
    8'h49, 8'h6E, 8'h52, 8'h39, 8'h24, 8'h0F, 8'h23, 8'h08,
    8'h20
  };

  // Segment pattern for a font index; indices past the table are blank.
  function automatic logic [7:0] font_lookup(input logic [IDX_W-1:0] idx);
    logic [7:0] pat;
    pat = 8'h00;
    if (int'(idx) < FONT_SIZE) begin
      pat = FONT_ROM[idx];
    end
    return pat;
  endfunction

  // ASCII byte to font index. Lower case folds onto upper case, and bytes
  // below the space or with the top bit set map to blank.
  function automatic logic [IDX_W-1:0] map_char(input logic [7:0] code);
    logic [7:0]       v;
    logic [IDX_W-1:0] idx;
    v   = code;
    idx = '0;
    if (!code[7]) begin
      if (v > 8'd96) begin
        v = v - 8'd32;
      end
      if (v >= 8'd32) begin
        idx = IDX_W'(v - 8'd32);
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/stdss_ram.sv =====
// Generic single-write, single-read RAM with registered, write-first read.
module stdss_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; a write to the same address in this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/stdss_store.sv =====
// Text store: three RAM copies give the three-character window each cycle.
module stdss_store (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [stdss_pkg::ADDR_W-1:0] wr_addr,
  input  logic [stdss_pkg::IDX_W-1:0]  wr_data,
  input  logic [stdss_pkg::ADDR_W-1:0] rd_addr,
  output stdss_pkg::window_t       window
);
  import stdss_pkg::*;

  localparam int PORTS = 3;

  logic [BUF_DEPTH-1:0] written;
  logic [ADDR_W-1:0]    addr  [PORTS];
  logic [IDX_W-1:0]     rdata [PORTS];
  logic [PORTS-1:0]     rd_written;

  // Window addresses follow the next scroll position.
  assign addr[0] = rd_addr;
  assign addr[1] = rd_addr + ADDR_W'(1);
  assign addr[2] = rd_addr + ADDR_W'(2);

  // One copy of the text per window slot.
  for (genvar p = 0; p < PORTS; p++) begin : g_copy
    stdss_ram #(
      .DEPTH (BUF_DEPTH),
      .WIDTH (IDX_W)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (addr[p]),
      .rdata (rdata[p])
    );
  end

  // Entries never written since reset read as blank.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= '0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      for (int p = 0; p < PORTS; p++) begin
        rd_written[p] <= written[addr[p]] || (wr_en && (wr_addr == addr[p]));
      end
    end
  end

  assign window.idx0 = rd_written[0] ? rdata[0] : '0;
  assign window.idx1 = rd_written[1] ? rdata[1] : '0;
  assign window.idx2 = rd_written[2] ? rdata[2] : '0;

endmodule

// ===== sv/stdss_glyph.sv =====
// Turns the character window into left and right digit patterns.
module stdss_glyph (
  input  stdss_pkg::window_t window,
  output stdss_pkg::glyph_t  glyph
);
  import stdss_pkg::*;

  logic dot_follows;

  // A dot after the left character lights its decimal point and is skipped.
  assign dot_follows = (window.idx1 == DOT_INDEX);

  always_comb begin
    glyph.skip_dot = dot_follows;
    glyph.left     = font_lookup(window.idx0);
    if (dot_follows) begin
      glyph.left  = glyph.left | DOT_BIT;
      glyph.right = font_lookup(window.idx2);
    end else begin
      glyph.right = font_lookup(window.idx1);
    end
  end

endmodule

// ===== sv/scrolling_two_digit_seven_segment.sv =====
// A refresh tick's segment transaction is registered and offered in the cycle after
// its acceptance. Throughput: one input transaction per cycle while the output is not
// stalled; the text window is read from the store RAMs at the next scroll position so
// a fetch never waits on a read. Append and end transactions produce no output
// transaction. Reset (synchronous): text reads as blank at once, no clearing pass;
// scroll interval returns to 50, text length to 1.
`include "scrolling_two_digit_seven_segment_assert.svh"

module scrolling_two_digit_seven_segment (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stdss_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stdss_pkg::out_item_t out_data
);
  import stdss_pkg::*;

  // State.
  logic [15:0]       scroll_interval;
  logic [15:0]       interval_count;
  logic [ADDR_W-1:0] text_length;
  logic [ADDR_W-1:0] write_pos;
  logic [ADDR_W-1:0] scroll_pos;
  logic              refresh_pending;
  logic [7:0]        left_pattern;
  logic [7:0]        right_pattern;
  logic              digit_phase;

  // Next values and decode.
  logic              in_fire;
  logic              is_append;
  logic              is_end;
  logic              is_tick;
  logic              do_fetch;
  logic [15:0]       count_inc;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_data;
  logic [ADDR_W:0]   scroll_step;
  logic              scroll_wrap;
  logic [ADDR_W-1:0] scroll_pos_next;
  logic [7:0]        left_next;
  logic [7:0]        right_next;
  window_t           window;
  glyph_t            glyph;

  // The output register frees as soon as its transaction is taken.
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_append = in_fire && (in_data.kind == KIND_APPEND);
  assign is_end    = in_fire && (in_data.kind == KIND_END);
  assign is_tick   = in_fire && (in_data.kind == KIND_TICK);

  // Store writes: appended characters, or the terminator on an end.
  assign wr_en   = (is_append && (write_pos < ADDR_W'(BUF_DEPTH - 1))) || is_end;
  assign wr_data = is_end ? '0 : map_char(in_data.char_code);

  stdss_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (write_pos),
    .wr_data (wr_data),
    .rd_addr (scroll_pos_next),
    .window  (window)
  );

  stdss_glyph u_glyph (
    .window (window),
    .glyph  (glyph)
  );

  // Fetch decision on a tick.
  assign count_inc = interval_count + 16'd1;
  assign do_fetch  = is_tick && ((count_inc > scroll_interval) || refresh_pending);

  // Scroll advance with wrap once past the second-to-last character.
  assign scroll_step = {1'b0, scroll_pos} + (glyph.skip_dot ? (ADDR_W+1)'(2) : (ADDR_W+1)'(1));
  assign scroll_wrap = ((ADDR_W+2)'(scroll_step) + (ADDR_W+2)'(2)) > (ADDR_W+2)'(text_length);

  always_comb begin
    scroll_pos_next = scroll_pos;
    if (is_end) begin
      scroll_pos_next = '0;
    end else if (do_fetch) begin
      scroll_pos_next = scroll_wrap ? '0 : scroll_step[ADDR_W-1:0];
    end
  end

  assign left_next  = do_fetch ? glyph.left : left_pattern;
  assign right_next = do_fetch ? glyph.right : right_pattern;

  // State and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_interval <= 16'd50;
      interval_count  <= '0;
      text_length     <= ADDR_W'(1);
      write_pos       <= '0;
      scroll_pos      <= '0;
      refresh_pending <= 1'b0;
      left_pattern    <= '0;
      right_pattern   <= '0;
      digit_phase     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        scroll_interval <= cfg_data;
      end
      scroll_pos <= scroll_pos_next;
      if (wr_en && is_append) begin
        write_pos <= write_pos + ADDR_W'(1);
      end
      if (is_end) begin
        text_length     <= write_pos;
        write_pos       <= '0;
        refresh_pending <= 1'b1;
      end
      if (is_tick) begin
        interval_count <= do_fetch ? '0 : count_inc;
        left_pattern   <= left_next;
        right_pattern  <= right_next;
        digit_phase    <= !digit_phase;
        if (do_fetch) begin
          refresh_pending <= 1'b0;
        end
      end
      if (is_tick) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload; no reset needed.
  always_ff @(posedge clk) begin
    if (is_tick) begin
      out_data.segments     <= digit_phase ? right_next : left_next;
      out_data.digit_select <= digit_phase;
    end
  end

  // Checks on the scroll window and the tick path.
  `STDSS_ASSERT(a_scroll_in_range, clk, rst, scroll_pos <= ADDR_W'(BUF_DEPTH - 3) || scroll_pos == '0, "scroll position past the last window")
  `STDSS_ASSERT(a_length_in_range, clk, rst, text_length <= ADDR_W'(BUF_DEPTH - 1), "text length past the store")
  `STDSS_ASSERT_NEXT(a_tick_result, clk, rst, is_tick, out_valid && (out_data.digit_select == $past(digit_phase)), "tick transaction did not produce its digit")
  `STDSS_ASSERT_NEXT(a_end_restarts, clk, rst, is_end, refresh_pending && (scroll_pos == '0) && (write_pos == '0), "end transaction did not restart the scroll")

endmodule
